// File: hdl/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

	localparam int TABLE_BITS_DEF = 12;
	localparam int SCORE_BITS_DEF = 16;

	localparam logic [2:0] CMD_LOOKUP   = 3'd0;
	localparam logic [2:0] CMD_CREATE   = 3'd1;
	localparam logic [2:0] CMD_WRITE    = 3'd2;
	localparam logic [2:0] CMD_CLR_DONE = 3'd3;
	localparam logic [2:0] CMD_CLR_ALL  = 3'd4;

	localparam logic [2:0] STS_FOUND   = 3'd0;
	localparam logic [2:0] STS_CREATED = 3'd1;
	localparam logic [2:0] STS_ABSENT  = 3'd2;
	localparam logic [2:0] STS_FULL    = 3'd3;
	localparam logic [2:0] STS_NULL    = 3'd4;
	localparam logic [2:0] STS_DONE    = 3'd5;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [63:0]        key;
		logic [11:0]        slot;
		logic signed [15:0] new_score;
		logic               new_node;
		logic               new_done;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [11:0]        slot_out;
		logic signed [15:0] score_out;
		logic               node_out;
		logic               done_out;
	} rsp_t;

	// per-field write enables of the slot memory
	typedef struct packed {
		logic key;
		logic data;
		logic done;
	} wr_en_t;

endpackage
`default_nettype wire

// File: hdl/lpht_mem.sv
`default_nettype none
module lpht_mem #(
	parameter int TABLE_BITS = lpht_pkg::TABLE_BITS_DEF,
	parameter int SCORE_BITS = lpht_pkg::SCORE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic [TABLE_BITS-1:0] rd_addr,
	output logic [63:0]                rd_key,
	output logic [SCORE_BITS-1:0]      rd_score,
	output logic                       rd_node,
	output logic                       rd_done,
	input  wire lpht_pkg::wr_en_t      wr_en,
	input  wire logic [TABLE_BITS-1:0] wr_addr,
	input  wire logic [63:0]           wr_key,
	input  wire logic [SCORE_BITS-1:0] wr_score,
	input  wire logic                  wr_node,
	input  wire logic                  wr_done
);

	localparam int SLOTS = 1 << TABLE_BITS;

	logic [63:0]         key_mem  [SLOTS];
	logic [SCORE_BITS:0] data_mem [SLOTS];
	logic                done_mem [SLOTS];

	logic [63:0]         rd_key_q;
	logic [SCORE_BITS:0] rd_data_q;
	logic                rd_done_q;

	always_ff @(posedge clk) begin
		if (wr_en.key) begin
			key_mem[wr_addr] <= wr_key;
		end
		rd_key_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en.data) begin
			data_mem[wr_addr] <= {wr_score, wr_node};
		end
		rd_data_q <= data_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en.done) begin
			done_mem[wr_addr] <= wr_done;
		end
		rd_done_q <= done_mem[rd_addr];
	end

	assign rd_key   = rd_key_q;
	assign rd_score = rd_data_q[SCORE_BITS:1];
	assign rd_node  = rd_data_q[0];
	assign rd_done  = rd_done_q;

endmodule
`default_nettype wire

// File: hdl/lpht_ctrl.sv
`default_nettype none
module lpht_ctrl #(
	parameter int TABLE_BITS = lpht_pkg::TABLE_BITS_DEF,
	parameter int SCORE_BITS = lpht_pkg::SCORE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire lpht_pkg::req_t        req,
	output logic                       busy,
	output logic [TABLE_BITS-1:0]      rd_addr,
	input  wire logic [63:0]           rd_key,
	input  wire logic [SCORE_BITS-1:0] rd_score,
	input  wire logic                  rd_node,
	input  wire logic                  rd_done,
	output lpht_pkg::wr_en_t           wr_en,
	output logic [TABLE_BITS-1:0]      wr_addr,
	output logic [63:0]                wr_key,
	output logic [SCORE_BITS-1:0]      wr_score,
	output logic                       wr_node,
	output logic                       wr_done,
	output logic                       emit,
	output lpht_pkg::rsp_t             emit_rsp
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	logic [1:0]            state_q, state_d;
	logic [TABLE_BITS-1:0] idx_q, idx_d;
	logic [TABLE_BITS-1:0] cnt_q, cnt_d;
	logic [63:0]           key_q, key_d;
	logic                  create_q, create_d;
	logic                  all_q, all_d;
	logic                  init_q, init_d;

	logic                  accept;
	logic [TABLE_BITS-1:0] slot_idx;
	logic [31:0]           new_sc_wide;
	logic [SCORE_BITS-1:0] new_sc;
	logic [31:0]           new_sc_out;
	logic [31:0]           rd_sc_out;
	logic                  slot_empty;
	logic                  slot_hit;

	assign accept      = start && (state_q == ST_IDLE);
	assign busy        = (state_q != ST_IDLE);
	assign slot_idx    = TABLE_BITS'(req.slot);
	assign new_sc_wide = 32'($signed(req.new_score));
	assign new_sc      = new_sc_wide[SCORE_BITS-1:0];
	assign new_sc_out  = 32'($signed(new_sc));
	assign rd_sc_out   = 32'($signed(rd_score));
	assign slot_empty  = (rd_key == 64'd0);
	assign slot_hit    = (rd_key == key_q);
	assign rd_addr     = idx_d;

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		key_d    = key_q;
		create_d = create_q;
		all_d    = all_q;
		init_d   = init_q;
		wr_en    = '0;
		wr_addr  = idx_q;
		wr_key   = key_q;
		wr_score = '0;
		wr_node  = 1'b0;
		wr_done  = 1'b0;
		emit     = 1'b0;
		emit_rsp = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req.cmd) inside
						lpht_pkg::CMD_LOOKUP, lpht_pkg::CMD_CREATE: begin
							if (req.key == 64'd0) begin
								emit            = 1'b1;
								emit_rsp.status = lpht_pkg::STS_NULL;
							end else begin
								key_d    = req.key;
								create_d = (req.cmd == lpht_pkg::CMD_CREATE);
								idx_d    = req.key[TABLE_BITS-1:0];
								cnt_d    = '0;
								state_d  = ST_PROBE;
							end
						end
						lpht_pkg::CMD_WRITE: begin
							wr_en.data        = 1'b1;
							wr_en.done        = 1'b1;
							wr_addr           = slot_idx;
							wr_score          = new_sc;
							wr_node           = req.new_node;
							wr_done           = req.new_done;
							emit              = 1'b1;
							emit_rsp.status   = lpht_pkg::STS_DONE;
							emit_rsp.slot_out = 12'(slot_idx);
							emit_rsp.score_out = new_sc_out[15:0];
							emit_rsp.node_out = req.new_node;
							emit_rsp.done_out = req.new_done;
						end
						lpht_pkg::CMD_CLR_DONE: begin
							idx_d   = '0;
							all_d   = 1'b0;
							state_d = ST_SWEEP;
						end
						lpht_pkg::CMD_CLR_ALL: begin
							idx_d   = '0;
							all_d   = 1'b1;
							state_d = ST_SWEEP;
						end
						default: begin
							emit            = 1'b1;
							emit_rsp.status = lpht_pkg::STS_DONE;
						end
					endcase
				end
			end
			ST_PROBE: begin
				if (slot_empty) begin
					state_d = ST_IDLE;
					emit    = 1'b1;
					if (create_q) begin
						wr_en             = '1;
						wr_addr           = idx_q;
						wr_key            = key_q;
						emit_rsp.status   = lpht_pkg::STS_CREATED;
						emit_rsp.slot_out = 12'(idx_q);
					end else begin
						emit_rsp.status = lpht_pkg::STS_ABSENT;
					end
				end else if (slot_hit) begin
					state_d            = ST_IDLE;
					emit               = 1'b1;
					emit_rsp.status    = lpht_pkg::STS_FOUND;
					emit_rsp.slot_out  = 12'(idx_q);
					emit_rsp.score_out = rd_sc_out[15:0];
					emit_rsp.node_out  = rd_node;
					emit_rsp.done_out  = rd_done;
				end else if (&cnt_q) begin
					state_d         = ST_IDLE;
					emit            = 1'b1;
					emit_rsp.status = lpht_pkg::STS_FULL;
				end else begin
					idx_d = idx_q + 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SWEEP: begin
				wr_en.done = 1'b1;
				wr_en.key  = all_q;
				wr_en.data = all_q;
				wr_key     = 64'd0;
				if (&idx_q) begin
					state_d         = ST_IDLE;
					init_d          = 1'b0;
					// no result for the sweep after reset
					emit            = !init_q;
					emit_rsp.status = lpht_pkg::STS_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// reset starts a sweep that empties the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			idx_q    <= '0;
			cnt_q    <= '0;
			create_q <= 1'b0;
			all_q    <= 1'b1;
			init_q   <= 1'b1;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			cnt_q    <= cnt_d;
			create_q <= create_d;
			all_q    <= all_d;
			init_q   <= init_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (state_q != ST_IDLE) || accept)
		else $error("result without request or work");

	a_sweep_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> wr_en.done && (wr_en.key == all_q) && (wr_key == 64'd0))
		else $error("sweep not clearing");

	a_probe_home: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.cmd == lpht_pkg::CMD_LOOKUP || req.cmd == lpht_pkg::CMD_CREATE)
			&& (req.key != 64'd0)
		|=> (state_q == ST_PROBE) && (idx_q == $past(req.key[TABLE_BITS-1:0]))
			&& (cnt_q == '0))
		else $error("probe not started at home slot");

	a_create_key: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en.key && (state_q == ST_PROBE)) |-> (wr_key != 64'd0) && slot_empty)
		else $error("create writes null key or over live slot");

endmodule
`default_nettype wire

// File: hdl/linear_probe_hash_table.sv
// lookup: slots probed from the home slot (one per cycle), result strobes after the last one
// write, null key and unknown command: result the cycle after the request, busy stays low
// clear done / clear table: a sweep over every slot, result strobes the cycle after the last
// throughput: one probe per cycle, bound by the single read port of the slot memory
// reset: busy while the sweep empties all 2^TABLE_BITS slots (4096 by default)
// results cannot be stalled: each strobe lasts one cycle
`default_nettype none
module linear_probe_hash_table #(
	parameter int TABLE_BITS = lpht_pkg::TABLE_BITS_DEF,
	parameter int SCORE_BITS = lpht_pkg::SCORE_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire lpht_pkg::req_t req,
	output logic                busy,
	output logic                rsp_valid,
	output lpht_pkg::rsp_t      rsp
);

	logic [TABLE_BITS-1:0] rd_addr;
	logic [63:0]           rd_key;
	logic [SCORE_BITS-1:0] rd_score;
	logic                  rd_node;
	logic                  rd_done;
	lpht_pkg::wr_en_t      wr_en;
	logic [TABLE_BITS-1:0] wr_addr;
	logic [63:0]           wr_key;
	logic [SCORE_BITS-1:0] wr_score;
	logic                  wr_node;
	logic                  wr_done;
	logic                  emit;
	lpht_pkg::rsp_t        emit_rsp;

	logic                  rsp_valid_q;
	lpht_pkg::rsp_t        rsp_q;

	lpht_ctrl #(
		.TABLE_BITS(TABLE_BITS),
		.SCORE_BITS(SCORE_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_score(rd_score),
		.rd_node (rd_node),
		.rd_done (rd_done),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_score(wr_score),
		.wr_node (wr_node),
		.wr_done (wr_done),
		.emit    (emit),
		.emit_rsp(emit_rsp)
	);

	lpht_mem #(
		.TABLE_BITS(TABLE_BITS),
		.SCORE_BITS(SCORE_BITS)
	) u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_score(rd_score),
		.rd_node (rd_node),
		.rd_done (rd_done),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_score(wr_score),
		.wr_node (wr_node),
		.wr_done (wr_done)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
